### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the priority queue design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: name");

// A condition that must be followed by a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(name, clk, rst, cond, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: name");

`endif

### design/spq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, operation and status codes, and the command broadcast to cells.
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam int ValueWidth  = 32;
   localparam int RankWidth   = 16;
   localparam int StatusWidth = 2;
   localparam int FillWidth   = 4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [StatusWidth-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic                         insert;
      logic                         remove;
      logic        [RankWidth-1:0]  rank;
      logic signed [ValueWidth-1:0] value;
   } cmd_type;

endpackage

### design/spq_cell.sv
// ---------------------------------------------------------------------------
// Priority queue cell
// Holds one entry, compares it against the broadcast rank and moves data
// to or from its neighbors.
// ---------------------------------------------------------------------------
module spq_cell (
   input  logic                                 clock,
   input  spq_pkg::cmd_type                     cmd,
   input  logic                                 occupied,
   input  logic                                 at_tail,
   input  logic                                 left_shift,
   input  logic signed [spq_pkg::ValueWidth-1:0] left_value,
   input  logic        [spq_pkg::RankWidth-1:0]  left_rank,
   input  logic signed [spq_pkg::ValueWidth-1:0] right_value,
   input  logic        [spq_pkg::RankWidth-1:0]  right_rank,
   output logic                                 shift_out,
   output logic signed [spq_pkg::ValueWidth-1:0] value_out,
   output logic        [spq_pkg::RankWidth-1:0]  rank_out
);

   logic signed [spq_pkg::ValueWidth-1:0] value_ff, value_in;
   logic        [spq_pkg::RankWidth-1:0]  rank_ff, rank_in;
   logic                                  greater;

   assign greater = occupied && (rank_ff > cmd.rank);

   always_comb begin
      if (cmd.insert) begin
         priority if (left_shift) begin
            value_in = left_value;
            rank_in  = left_rank;
         end else if (greater || at_tail) begin
            value_in = cmd.value;
            rank_in  = cmd.rank;
         end else begin
            value_in = value_ff;
            rank_in  = rank_ff;
         end
      end else if (cmd.remove) begin
         value_in = right_value;
         rank_in  = right_rank;
      end else begin
         value_in = value_ff;
         rank_in  = rank_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

   assign shift_out = greater;
   assign value_out = value_ff;
   assign rank_out  = rank_ff;

endmodule

### design/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// Sorted priority queue
// Minimum priority queue kept in ascending rank order in a row of cells.
// ---------------------------------------------------------------------------
// The queue takes one insert or remove request in every cycle once reset is
// released; busy is high only during reset and the cycle after it. Each request
// gives one result one cycle after acceptance, with rsp_strobe high for that
// single cycle, and the receiver must take it then. The one-cycle figure is
// set by the row of cells: every cell compares its rank with the request and
// moves its entry one place toward its neighbor in the same clock. Entries of
// equal rank leave in arrival order. An insert into a full queue or a remove
// from an empty one reports its status and leaves the contents unchanged.
module sorted_priority_queue #(
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_op,
   input  logic signed [spq_pkg::ValueWidth-1:0] req_item_value,
   input  logic        [spq_pkg::RankWidth-1:0]  req_item_rank,
   output logic                                  rsp_strobe,
   output logic        [spq_pkg::StatusWidth-1:0] rsp_status,
   output logic signed [spq_pkg::ValueWidth-1:0] rsp_removed_value,
   output logic        [spq_pkg::RankWidth-1:0]  rsp_removed_rank,
   output logic        [spq_pkg::FillWidth-1:0]  rsp_fill
);

`include "assert_macros.svh"

   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   logic                                   busy_ff;
   logic                                   accept;
   logic                                   full;
   logic                                   empty;
   logic                                   ovf_req;
   logic                                   ovf_rsp;
   logic [CountWidth-1:0]                  count_ff, count_in;
   logic                                   strobe_ff;
   logic [spq_pkg::StatusWidth-1:0]        status_ff, status_in;
   logic signed [spq_pkg::ValueWidth-1:0]  rem_value_ff, rem_value_in;
   logic [spq_pkg::RankWidth-1:0]          rem_rank_ff, rem_rank_in;
   spq_pkg::cmd_type                       cmd;

   logic                                   cell_shift [DEPTH];
   logic signed [spq_pkg::ValueWidth-1:0]  cell_value [DEPTH];
   logic [spq_pkg::RankWidth-1:0]          cell_rank  [DEPTH];

   assign accept  = start && !busy_ff;
   assign full    = (count_ff == FullCount);
   assign empty   = (count_ff == '0);
   assign ovf_req = accept && (req_op == spq_pkg::OP_INSERT) && full;
   assign ovf_rsp = (rsp_status == spq_pkg::STATUS_OVERFLOW);

   always_comb begin
      cmd.insert   = accept && (req_op == spq_pkg::OP_INSERT) && !full;
      cmd.remove   = accept && (req_op == spq_pkg::OP_REMOVE) && !empty;
      cmd.rank     = req_item_rank;
      cmd.value    = req_item_value;
      count_in     = count_ff;
      status_in    = spq_pkg::STATUS_OK;
      rem_value_in = '0;
      rem_rank_in  = '0;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.remove) begin
         count_in     = count_ff - 1'b1;
         rem_value_in = cell_value[0];
         rem_rank_in  = cell_rank[0];
      end
      if (req_op == spq_pkg::OP_INSERT && full) begin
         status_in = spq_pkg::STATUS_OVERFLOW;
      end
      if (req_op == spq_pkg::OP_REMOVE && empty) begin
         status_in = spq_pkg::STATUS_UNDERFLOW;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                                  left_shift;
      logic signed [spq_pkg::ValueWidth-1:0] left_value;
      logic [spq_pkg::RankWidth-1:0]         left_rank;
      logic signed [spq_pkg::ValueWidth-1:0] right_value;
      logic [spq_pkg::RankWidth-1:0]         right_rank;

      if (i == 0) begin : g_head
         assign left_shift = 1'b0;
         assign left_value = cmd.value;
         assign left_rank  = cmd.rank;
      end else begin : g_body
         assign left_shift = cell_shift[i-1];
         assign left_value = cell_value[i-1];
         assign left_rank  = cell_rank[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
         assign right_rank  = cell_rank[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_rank  = cell_rank[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CountWidth'(i) < count_ff),
         .at_tail     (CountWidth'(i) == count_ff),
         .left_shift  (left_shift),
         .left_value  (left_value),
         .left_rank   (left_rank),
         .right_value (right_value),
         .right_rank  (right_rank),
         .shift_out   (cell_shift[i]),
         .value_out   (cell_value[i]),
         .rank_out    (cell_rank[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      rem_value_ff <= rem_value_in;
      rem_rank_ff  <= rem_rank_in;
   end

   assign busy              = busy_ff;
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = rem_value_ff;
   assign rsp_removed_rank  = rem_rank_ff;
   assign rsp_fill          = spq_pkg::FillWidth'(count_ff);

   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= FullCount)
   `SPQ_ASSERT_NEXT(a_result_follows, clock, reset, accept, rsp_strobe)
   `SPQ_ASSERT_NEXT(a_overflow_holds, clock, reset, ovf_req, ovf_rsp && $stable(count_ff))
   `SPQ_ASSERT_NEXT(a_remove_count, clock, reset, cmd.remove, count_ff == $past(count_ff) - 1'b1)

endmodule

### test/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove requests in random bursts and predicts every
// response from a sorted model of the queue held here, checking status,
// removed entry and fill. Directed requests cover the rank and value extremes,
// ties, a full queue and an empty one; random phases then swing the fill
// level between empty and full.
// ---------------------------------------------------------------------------
module sorted_priority_queue_tb;

   localparam int QueueDepth  = 8;
   localparam int StallLimit  = 2000;
   localparam int RandomCount = 650;

   typedef struct {
      bit                                    pause;
      logic                                  op;
      logic signed [spq_pkg::ValueWidth-1:0] value;
      logic        [spq_pkg::RankWidth-1:0]  rank;
   } request_type;

   typedef struct {
      logic        [spq_pkg::StatusWidth-1:0] status;
      logic signed [spq_pkg::ValueWidth-1:0]  value;
      logic        [spq_pkg::RankWidth-1:0]   rank;
      logic        [spq_pkg::FillWidth-1:0]   fill;
   } outcome_type;

   logic                                   clock;
   logic                                   reset          = 1'b1;
   logic                                   start          = 1'b0;
   logic                                   req_op         = spq_pkg::OP_INSERT;
   logic signed [spq_pkg::ValueWidth-1:0]  req_item_value = '0;
   logic        [spq_pkg::RankWidth-1:0]   req_item_rank  = '0;
   logic                                   busy;
   logic                                   rsp_strobe;
   logic        [spq_pkg::StatusWidth-1:0] rsp_status;
   logic signed [spq_pkg::ValueWidth-1:0]  rsp_removed_value;
   logic        [spq_pkg::RankWidth-1:0]   rsp_removed_rank;
   logic        [spq_pkg::FillWidth-1:0]   rsp_fill;

   request_type pending_requests[$];
   outcome_type expected_outcomes[$];

   logic signed [spq_pkg::ValueWidth-1:0] held_values[QueueDepth];
   logic        [spq_pkg::RankWidth-1:0]  held_ranks[QueueDepth];
   int held_count = 0;

   int  error_count = 0;
   int  stall_cycles = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   bit  drained = 1'b1;

   sorted_priority_queue #(
      .DEPTH(QueueDepth)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_item_value(req_item_value),
      .req_item_rank(req_item_rank),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_removed_value(rsp_removed_value),
      .rsp_removed_rank(rsp_removed_rank),
      .rsp_fill(rsp_fill)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic outcome_type apply_request(
         logic op,
         logic signed [spq_pkg::ValueWidth-1:0] value,
         logic [spq_pkg::RankWidth-1:0] rank);
      outcome_type res;
      int slot;
      res.status = spq_pkg::STATUS_OK;
      res.value  = '0;
      res.rank   = '0;
      if (op == spq_pkg::OP_INSERT) begin
         if (held_count >= QueueDepth) begin
            res.status = spq_pkg::STATUS_OVERFLOW;
         end else begin
            slot = 0;
            for (int i = 0; i < held_count; i++) begin
               if (held_ranks[i] <= rank) slot = i + 1;
            end
            for (int i = held_count; i > slot; i--) begin
               held_values[i] = held_values[i-1];
               held_ranks[i]  = held_ranks[i-1];
            end
            held_values[slot] = value;
            held_ranks[slot]  = rank;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = spq_pkg::STATUS_UNDERFLOW;
         end else begin
            res.value = held_values[0];
            res.rank  = held_ranks[0];
            for (int i = 0; i + 1 < held_count; i++) begin
               held_values[i] = held_values[i+1];
               held_ranks[i]  = held_ranks[i+1];
            end
            held_count--;
         end
      end
      res.fill = spq_pkg::FillWidth'(held_count);
      return res;
   endfunction

   task automatic add_request(logic op, logic signed [spq_pkg::ValueWidth-1:0] value,
                              logic [spq_pkg::RankWidth-1:0] rank);
      request_type req;
      req.pause = 1'b0;
      req.op    = op;
      req.value = value;
      req.rank  = rank;
      pending_requests.push_back(req);
   endtask

   task automatic add_pause();
      request_type req;
      req.pause = 1'b1;
      req.op    = spq_pkg::OP_INSERT;
      req.value = '0;
      req.rank  = '0;
      pending_requests.push_back(req);
   endtask

   function automatic logic [spq_pkg::RankWidth-1:0] pick_rank(int mode);
      case (mode)
         0: return spq_pkg::RankWidth'($urandom_range(0, 3));
         1: return spq_pkg::RankWidth'($urandom_range(0, 255));
         2: return ($urandom_range(0, 1) == 1) ? {spq_pkg::RankWidth{1'b1}} : '0;
         default: return spq_pkg::RankWidth'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string field, longint want, longint got);
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      error_count++;
   endtask

   always @(negedge clock) begin
      drained <= (expected_outcomes.size() == 0);
   end

   always @(posedge clock) begin
      logic next_start;
      next_start = 1'b0;
      if (reset) begin
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (start && !busy) void'(pending_requests.pop_front());
         if (start && busy) begin
            next_start = 1'b1;
         end else if (pending_requests.size() > 0 && pending_requests[0].pause) begin
            if (!start && drained) void'(pending_requests.pop_front());
         end else if (pending_requests.size() > 0) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               burst_left--;
               next_start = 1'b1;
               req_op         <= pending_requests[0].op;
               req_item_value <= pending_requests[0].value;
               req_item_rank  <= pending_requests[0].rank;
            end
         end
      end
      start <= next_start;
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: response with no request outstanding, status %0d fill %0d",
                        $time, rsp_status, rsp_fill);
               error_count++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
               if (rsp_removed_value !== want.value)
                  report_mismatch("removed_value", want.value, rsp_removed_value);
               if (rsp_removed_rank !== want.rank)
                  report_mismatch("removed_rank", want.rank, rsp_removed_rank);
               if (rsp_fill !== want.fill)
                  report_mismatch("fill", want.fill, rsp_fill);
            end
         end
         if (start && !busy) begin
            expected_outcomes.push_back(apply_request(req_op, req_item_value, req_item_rank));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("%0t: no progress for %0d cycles", $time, StallLimit);
         $display("sorted_priority_queue: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int insert_pct;
      int rank_mode;
      int random_made;

      add_request(spq_pkg::OP_REMOVE, 32'sh5A5A_A5A5, 16'hBEEF);
      add_request(spq_pkg::OP_INSERT, 32'sd1, 16'd100);
      add_request(spq_pkg::OP_INSERT, 32'sd2, 16'd100);
      add_request(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 16'h0000);
      add_request(spq_pkg::OP_INSERT, 32'sh8000_0000, 16'hFFFF);
      add_request(spq_pkg::OP_INSERT, -32'sd1, 16'd50);
      add_request(spq_pkg::OP_INSERT, 32'sd3, 16'd100);
      add_request(spq_pkg::OP_INSERT, 32'sd5, 16'hFFFF);
      add_request(spq_pkg::OP_INSERT, 32'sd6, 16'h0000);
      add_request(spq_pkg::OP_INSERT, 32'sd7, 16'd7);
      for (int i = 0; i < QueueDepth; i++) begin
         add_request(spq_pkg::OP_REMOVE, '1, '1);
      end
      add_request(spq_pkg::OP_REMOVE, '0, '0);
      add_request(spq_pkg::OP_INSERT, 32'sd0, 16'd1);
      add_request(spq_pkg::OP_REMOVE, 32'sd9, 16'd9);
      add_pause();

      random_made = 0;
      while (random_made < RandomCount) begin
         case ($urandom_range(0, 3))
            0: insert_pct = 15;
            1: insert_pct = 50;
            2: insert_pct = 70;
            default: insert_pct = 90;
         endcase
         rank_mode = $urandom_range(0, 3);
         for (int i = 0; i < 40 && random_made < RandomCount; i++) begin
            if ($urandom_range(1, 100) <= insert_pct)
               add_request(spq_pkg::OP_INSERT, $urandom, pick_rank(rank_mode));
            else
               add_request(spq_pkg::OP_REMOVE, $urandom, spq_pkg::RankWidth'($urandom));
            random_made++;
            if (random_made == RandomCount / 2) add_pause();
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || start || !drained) @(negedge clock);
      repeat (4) @(posedge clock);

      if (expected_outcomes.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_outcomes.size());
         error_count++;
      end
      if (error_count == 0)
         $display("sorted_priority_queue: match");
      else
         $display("sorted_priority_queue: mismatch");
      $finish;
   end

endmodule
